[hw/rtl/ray_box_slab_intersect_unit_defines.svh]
// Assertion macros shared by the ray/box unit checker.
// No dependencies; included by the checker file.
`ifndef RAY_BOX_SLAB_INTERSECT_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RBSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ray box unit: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ray box unit: next-cycle check failed");

`endif

[hw/rtl/rbsi_pkg.sv]
// Shared widths, constants and types for the ray/box slab unit.
// No dependencies.
package rbsi_pkg;

   localparam int CoordW = 32;   // Q16.16 coordinate
   localparam int QuoW   = 48;   // quotient magnitude bits
   localparam int DenW   = 32;   // divisor magnitude bits
   localparam int TW     = 50;   // signed t parameter width
   localparam int Lanes  = 6;    // two divisions per axis
   localparam int Axes   = 3;

   localparam logic signed [TW-1:0] TNegInf = {2'b11, 48'd0};
   localparam logic signed [TW-1:0] TPosInf = {2'b01, 48'd0};

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      logic [Axes-1:0][CoordW-1:0] org;
      logic [Axes-1:0][CoordW-1:0] dir;
      logic [Axes-1:0]             dir_zero;
      logic                        miss;
      logic [Lanes-1:0]            neg;
   } side_type;

endpackage

[hw/rtl/ray_box_slab_intersect_unit.sv]
// Ray versus axis-aligned box test (slab method), signed Q16.16, fully pipelined.
// Depends on rbsi_pkg and rbsi_div_pipe.
//
// One ray/box beat is taken every cycle while the pipe advances; its result beat passes
// one input stage, 48 divider stages (one quotient bit per stage for
// the six (bound - origin) / direction quotients), then six stages for
// sign fix-up, per-axis min/max, the min/max across axes, hit and clamping
// of tmin, the three direction*tmin products, and the point sum with
// saturation in the output register. The whole pipe moves as one when the
// output register is empty or being drained, so req_ready follows rsp_ready
// while a result is held. Zero direction components bound nothing when the
// origin is inside the slab and force a miss otherwise; on a miss
// entry_distance and the point are zero.
module ray_box_slab_intersect_unit
   import rbsi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [31:0]      req_box_min_x,
   input  logic [31:0]      req_box_min_y,
   input  logic [31:0]      req_box_min_z,
   input  logic [31:0]      req_box_max_x,
   input  logic [31:0]      req_box_max_y,
   input  logic [31:0]      req_box_max_z,
   input  logic [31:0]      req_ray_origin_x,
   input  logic [31:0]      req_ray_origin_y,
   input  logic [31:0]      req_ray_origin_z,
   input  logic [31:0]      req_ray_dir_x,
   input  logic [31:0]      req_ray_dir_y,
   input  logic [31:0]      req_ray_dir_z,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_hit,
   output logic             rsp_hit_ahead,
   output logic [31:0]      rsp_entry_distance,
   output logic [31:0]      rsp_point_x,
   output logic [31:0]      rsp_point_y,
   output logic [31:0]      rsp_point_z
);

   localparam int SideW = $bits(side_type);

   // pipe advances when the output slot is free or being taken
   logic adv;
   logic g_valid_ff;
   assign adv       = ~g_valid_ff | rsp_ready;
   assign req_ready = adv;

   // ---------------- stage A: differences, magnitudes, zero-direction checks
   coord_type lo [Axes];
   coord_type hi [Axes];
   coord_type og [Axes];
   coord_type dr [Axes];

   assign lo[0] = req_box_min_x;  assign lo[1] = req_box_min_y;  assign lo[2] = req_box_min_z;
   assign hi[0] = req_box_max_x;  assign hi[1] = req_box_max_y;  assign hi[2] = req_box_max_z;
   assign og[0] = req_ray_origin_x;
   assign og[1] = req_ray_origin_y;
   assign og[2] = req_ray_origin_z;
   assign dr[0] = req_ray_dir_x;  assign dr[1] = req_ray_dir_y;  assign dr[2] = req_ray_dir_z;

   logic [Lanes-1:0][QuoW-1:0] a_num_in;
   logic [Lanes-1:0][DenW-1:0] a_den_in;
   side_type                   a_side_in;

   always_comb begin
      logic signed [CoordW:0] dlo;
      logic signed [CoordW:0] dhi;
      logic [CoordW:0]        mlo;
      logic [CoordW:0]        mhi;
      logic [CoordW-1:0]      dmag;
      coord_type              s_lo;
      coord_type              s_hi;
      a_side_in = '0;
      for (int a = 0; a < Axes; a++) begin
         dlo  = {lo[a][CoordW-1], lo[a]} - {og[a][CoordW-1], og[a]};
         dhi  = {hi[a][CoordW-1], hi[a]} - {og[a][CoordW-1], og[a]};
         mlo  = dlo[CoordW] ? -dlo : dlo;
         mhi  = dhi[CoordW] ? -dhi : dhi;
         dmag = dr[a][CoordW-1] ? -dr[a] : dr[a];
         a_num_in[a]      = {mlo[CoordW-1:0], 16'd0};
         a_num_in[a+Axes] = {mhi[CoordW-1:0], 16'd0};
         a_den_in[a]      = dmag;
         a_den_in[a+Axes] = dmag;
         a_side_in.neg[a]      = dlo[CoordW] ^ dr[a][CoordW-1];
         a_side_in.neg[a+Axes] = dhi[CoordW] ^ dr[a][CoordW-1];
         a_side_in.org[a]      = og[a];
         a_side_in.dir[a]      = dr[a];
         a_side_in.dir_zero[a] = (dr[a] == '0);
         s_lo = (lo[a] < hi[a]) ? lo[a] : hi[a];
         s_hi = (lo[a] < hi[a]) ? hi[a] : lo[a];
         if (dr[a] == '0 && (og[a] < s_lo || og[a] > s_hi)) begin
            a_side_in.miss = 1'b1;
         end
      end
   end

   logic                       a_valid_ff;
   logic [Lanes-1:0][QuoW-1:0] a_num_ff;
   logic [Lanes-1:0][DenW-1:0] a_den_ff;
   side_type                   a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
      if (adv) begin
         a_num_ff  <= a_num_in;
         a_den_ff  <= a_den_in;
         a_side_ff <= a_side_in;
      end
   end

   // ---------------- divider: 48 stages
   logic                       dv_valid;
   logic [Lanes-1:0][QuoW-1:0] dv_quo;
   logic [SideW-1:0]           dv_side_raw;
   side_type                   dv_side;

   rbsi_div_pipe #(
      .LANES  (Lanes),
      .NUM_W  (QuoW),
      .DEN_W  (DenW),
      .SIDE_W (SideW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (a_valid_ff),
      .in_num    (a_num_ff),
      .in_den    (a_den_ff),
      .in_side   (a_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side_raw)
   );
   assign dv_side = side_type'(dv_side_raw);

   // ---------------- stage B: signed quotients
   logic                   b_valid_ff;
   logic signed [TW-1:0]   b_q_ff [Lanes];
   side_type               b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= dv_valid;
      end
      if (adv) begin
         for (int l = 0; l < Lanes; l++) begin
            b_q_ff[l] <= dv_side.neg[l] ? -$signed({2'b00, dv_quo[l]})
                                        :  $signed({2'b00, dv_quo[l]});
         end
         b_side_ff <= dv_side;
      end
   end

   // ---------------- stage C: per-axis entry and exit
   logic                 c_valid_ff;
   logic signed [TW-1:0] c_en_ff [Axes];
   logic signed [TW-1:0] c_ex_ff [Axes];
   side_type             c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
      if (adv) begin
         for (int a = 0; a < Axes; a++) begin
            if (b_side_ff.dir_zero[a]) begin
               c_en_ff[a] <= TNegInf;
               c_ex_ff[a] <= TPosInf;
            end else if (b_q_ff[a] < b_q_ff[a+Axes]) begin
               c_en_ff[a] <= b_q_ff[a];
               c_ex_ff[a] <= b_q_ff[a+Axes];
            end else begin
               c_en_ff[a] <= b_q_ff[a+Axes];
               c_ex_ff[a] <= b_q_ff[a];
            end
         end
         c_side_ff <= b_side_ff;
      end
   end

   // ---------------- stage D: tmin / tmax across axes
   logic                 d_valid_ff;
   logic signed [TW-1:0] d_tmin_ff;
   logic signed [TW-1:0] d_tmax_ff;
   side_type             d_side_ff;
   logic signed [TW-1:0] d_tmin_in;
   logic signed [TW-1:0] d_tmax_in;

   always_comb begin
      d_tmin_in = c_en_ff[0];
      d_tmax_in = c_ex_ff[0];
      for (int a = 1; a < Axes; a++) begin
         if (c_en_ff[a] > d_tmin_in) d_tmin_in = c_en_ff[a];
         if (c_ex_ff[a] < d_tmax_in) d_tmax_in = c_ex_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
      if (adv) begin
         d_tmin_ff <= d_tmin_in;
         d_tmax_ff <= d_tmax_in;
         d_side_ff <= c_side_ff;
      end
   end

   // ---------------- stage E: hit flags, clamp tmin to 32 bits
   logic      e_valid_ff;
   logic      e_hit_ff;
   logic      e_ahead_ff;
   coord_type e_tsat_ff;
   side_type  e_side_ff;
   logic      e_hit_in;
   coord_type e_tsat_in;

   always_comb begin
      e_hit_in = ~d_side_ff.miss && (d_tmax_ff >= d_tmin_ff);
      if (d_tmin_ff[TW-1:CoordW-1] == {(TW-CoordW+1){d_tmin_ff[TW-1]}}) begin
         e_tsat_in = d_tmin_ff[CoordW-1:0];
      end else if (d_tmin_ff[TW-1]) begin
         e_tsat_in = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
         e_tsat_in = {1'b0, {(CoordW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
      if (adv) begin
         e_hit_ff   <= e_hit_in;
         e_ahead_ff <= e_hit_in && (d_tmax_ff > 0);
         e_tsat_ff  <= e_tsat_in;
         e_side_ff  <= d_side_ff;
      end
   end

   // ---------------- stage F: direction * tmin
   logic                       f_valid_ff;
   logic                       f_hit_ff;
   logic                       f_ahead_ff;
   coord_type                  f_tsat_ff;
   logic signed [2*CoordW-1:0] f_prod_ff [Axes];
   coord_type                  f_org_ff  [Axes];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= e_valid_ff;
      end
      if (adv) begin
         f_hit_ff   <= e_hit_ff;
         f_ahead_ff <= e_ahead_ff;
         f_tsat_ff  <= e_tsat_ff;
         for (int a = 0; a < Axes; a++) begin
            f_prod_ff[a] <= $signed(e_side_ff.dir[a]) * e_tsat_ff;
            f_org_ff[a]  <= e_side_ff.org[a];
         end
      end
   end

   // ---------------- stage G: point = origin + floor(prod / 2^16), saturate
   logic      g_hit_ff;
   logic      g_ahead_ff;
   coord_type g_dist_ff;
   coord_type g_pt_ff [Axes];
   coord_type g_pt_in [Axes];

   always_comb begin
      logic signed [2*CoordW-17:0] sh;
      logic signed [2*CoordW-16:0] sum;
      for (int a = 0; a < Axes; a++) begin
         sh  = f_prod_ff[a][2*CoordW-1:16];   // arithmetic shift = floor
         sum = {{(2*CoordW-15-CoordW){f_org_ff[a][CoordW-1]}}, f_org_ff[a]}
             + {sh[2*CoordW-17], sh};
         if (sum[2*CoordW-16:CoordW-1] == {(CoordW-14){sum[2*CoordW-16]}}) begin
            g_pt_in[a] = sum[CoordW-1:0];
         end else if (sum[2*CoordW-16]) begin
            g_pt_in[a] = {1'b1, {(CoordW-1){1'b0}}};
         end else begin
            g_pt_in[a] = {1'b0, {(CoordW-1){1'b1}}};
         end
         if (!f_hit_ff) g_pt_in[a] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= f_valid_ff;
      end
      if (adv) begin
         g_hit_ff   <= f_hit_ff;
         g_ahead_ff <= f_ahead_ff;
         g_dist_ff  <= f_hit_ff ? f_tsat_ff : '0;
         for (int a = 0; a < Axes; a++) begin
            g_pt_ff[a] <= g_pt_in[a];
         end
      end
   end

   assign rsp_valid          = g_valid_ff;
   assign rsp_hit            = g_hit_ff;
   assign rsp_hit_ahead      = g_ahead_ff;
   assign rsp_entry_distance = g_dist_ff;
   assign rsp_point_x        = g_pt_ff[0];
   assign rsp_point_y        = g_pt_ff[1];
   assign rsp_point_z        = g_pt_ff[2];

endmodule

[hw/rtl/rbsi_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Depends on rbsi_pkg.
module rbsi_div_pipe
   import rbsi_pkg::*;
#(
   parameter int LANES  = Lanes,
   parameter int NUM_W  = QuoW,
   parameter int DEN_W  = DenW,
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]  in_num,
   input  logic [LANES-1:0][DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0]            out_side
);

   logic                        valid_ff [NUM_W];
   logic [LANES-1:0][NUM_W-1:0] nq_ff    [NUM_W];
   logic [LANES-1:0][DEN_W-1:0] rem_ff   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff   [NUM_W];
   logic [SIDE_W-1:0]           side_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic                        v_src;
      logic [LANES-1:0][NUM_W-1:0] nq_src;
      logic [LANES-1:0][DEN_W-1:0] rem_src;
      logic [LANES-1:0][DEN_W-1:0] den_src;
      logic [SIDE_W-1:0]           side_src;
      logic [LANES-1:0][NUM_W-1:0] nq_in;
      logic [LANES-1:0][DEN_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign nq_src   = in_num;
         assign rem_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[s-1];
         assign nq_src   = nq_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] r2;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            r2 = {rem_src[l], nq_src[l][NUM_W-1]};
            ge = (r2 >= {1'b0, den_src[l]});
            if (ge) begin
               r2 = r2 - {1'b0, den_src[l]};
            end
            rem_in[l] = r2[DEN_W-1:0];
            nq_in[l]  = {nq_src[l][NUM_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= v_src;
         end
         if (advance) begin
            nq_ff[s]   <= nq_in;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

[hw/rtl/ray_box_slab_intersect_unit_checker.sv]
// Port-level checks for the ray/box unit, bound to the top level.
// Depends on ray_box_slab_intersect_unit_defines.svh.
`include "ray_box_slab_intersect_unit_defines.svh"

module ray_box_slab_intersect_unit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_box_min_x,
   input logic [31:0] req_box_min_y,
   input logic [31:0] req_box_min_z,
   input logic [31:0] req_box_max_x,
   input logic [31:0] req_box_max_y,
   input logic [31:0] req_box_max_z,
   input logic [31:0] req_ray_origin_x,
   input logic [31:0] req_ray_origin_y,
   input logic [31:0] req_ray_origin_z,
   input logic [31:0] req_ray_dir_x,
   input logic [31:0] req_ray_dir_y,
   input logic [31:0] req_ray_dir_z,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic        rsp_hit_ahead,
   input logic [31:0] rsp_entry_distance,
   input logic [31:0] rsp_point_x,
   input logic [31:0] rsp_point_y,
   input logic [31:0] rsp_point_z
);

   // held result beat keeps its hit flag, entry distance and x point
   `RBSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hit) && $stable(rsp_entry_distance) && $stable(rsp_point_x))

   // empty output slot means the pipe is moving
   `RBSI_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   `RBSI_ASSERT_SAME(a_ahead_needs_hit, clock, reset, rsp_valid && rsp_hit_ahead, rsp_hit)

   `RBSI_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_entry_distance == 32'd0 && rsp_point_x == 32'd0 &&
      rsp_point_y == 32'd0 && rsp_point_z == 32'd0)

endmodule

bind ray_box_slab_intersect_unit ray_box_slab_intersect_unit_checker u_checker (.*);
